[rtl/slxfp_pkg.sv]
// package for the sync/length/xor frame parser
// holds byte codes, parse modes, byte roles, status codes and the result struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slxfp_pkg;

    // frame constants
    localparam logic [7:0]  SYNC_BYTE        = 8'h5A;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd256;
    localparam int          COUNT_W          = 17;
    localparam int          HEADER_BYTES     = 4;
    localparam logic [COUNT_W-1:0] CNT_COMMAND  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] CNT_LEN_HIGH = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] CNT_SYNC     = COUNT_W'(1);

    // parser modes
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_BODY   = 2'd2
    } mode_t;

    // role of each byte in the frame
    typedef enum logic [2:0] {
        ROLE_IGNORED  = 3'd0,
        ROLE_SYNC     = 3'd1,
        ROLE_COMMAND  = 3'd2,
        ROLE_LEN_HIGH = 3'd3,
        ROLE_LEN_LOW  = 3'd4,
        ROLE_PAYLOAD  = 3'd5,
        ROLE_CHECKSUM = 3'd6,
        ROLE_TRAILER  = 3'd7
    } role_t;

    // frame verdict
    typedef enum logic [1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_GOOD      = 2'd1,
        STATUS_TOO_LONG  = 2'd2,
        STATUS_BAD_CHECK = 2'd3
    } status_t;

    // one result transaction
    typedef struct packed {
        logic [7:0] data_byte;
        role_t      byte_role;
        logic       frame_done;
        status_t    frame_status;
    } result_t;

endpackage

`default_nettype wire

[rtl/sync_length_xor_frame_parser.sv]
// sync/length/xor frame parser: each received byte is echoed with its frame role
// path: an accepted byte waits in the input register, is parsed once the result
// register is free, and its result is offered from there: two register stages (input, result)
// throughput: one byte per cycle while the result register is free; out_ready low stalls it
// reset: asynchronous active low; parser idles waiting for sync, max length 256
// built from slxfp_in_stage, slxfp_parse_core and slxfp_out_stage; uses slxfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module sync_length_xor_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [15:0] cfg_write_data,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        rx_valid,
    output logic             rx_ready,
    output logic [7:0]       data_byte,
    output logic [2:0]       byte_role,
    output logic             frame_done,
    output logic [1:0]       frame_status,
    output logic             out_valid,
    input  wire logic        out_ready
);

    import slxfp_pkg::*;

    logic    [7:0] byte_q;
    logic          byte_valid;
    logic          out_free;
    logic          fire;
    result_t       result_d;
    result_t       result_q;

    // a byte moves from input register to result register when both allow it
    assign fire = byte_valid && out_free;

    // input register
    slxfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .byte_q   (byte_q),
        .valid_q  (byte_valid),
        .take     (fire)
    );

    // parse logic and state
    slxfp_parse_core u_parse_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .byte_in        (byte_q),
        .fire           (fire),
        .result         (result_d)
    );

    // result register
    slxfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .result_d  (result_d),
        .load      (fire),
        .free      (out_free),
        .result_q  (result_q),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // result fields
    assign data_byte    = result_q.data_byte;
    assign byte_role    = result_q.byte_role;
    assign frame_done   = result_q.frame_done;
    assign frame_status = result_q.frame_status;

endmodule

`default_nettype wire

[rtl/slxfp_in_stage.sv]
// input register stage of the frame parser
// captures one received byte per transaction; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

module slxfp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] rx_byte,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    output logic [7:0]      byte_q,
    output logic            valid_q,
    input  wire logic       take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // free when empty or when the held byte moves on this cycle
    assign rx_ready = !valid_reg || take;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (rx_valid && rx_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_q  = byte_reg;
    assign valid_q = valid_reg;

endmodule

`default_nettype wire

[rtl/slxfp_parse_core.sv]
// frame parse state machine with running xor, byte counter and length check
// uses slxfp_pkg for modes, roles, status codes and the result struct
`timescale 1ns / 1ps
`default_nettype none

module slxfp_parse_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [15:0]      cfg_write_data,
    input  wire logic [7:0]       byte_in,
    input  wire logic             fire,
    output slxfp_pkg::result_t    result
);

    import slxfp_pkg::*;

    mode_t                mode_reg, mode_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [15:0]          len_reg, len_next;
    logic [7:0]           xor_reg, xor_next;
    logic                 match_reg, match_next;
    logic [15:0]          max_len_reg;

    logic [COUNT_W-1:0]   count_inc;
    logic [COUNT_W-1:0]   payload_end;
    logic [COUNT_W-1:0]   checksum_pos;
    logic [15:0]          len_full;
    logic                 len_too_big;

    // shared arithmetic
    assign count_inc    = count_reg + COUNT_W'(1);
    assign payload_end  = {1'b0, len_reg} + COUNT_W'(HEADER_BYTES);
    assign checksum_pos = {1'b0, len_reg} + COUNT_W'(HEADER_BYTES + 1);
    assign len_full     = {len_reg[15:8], byte_in};
    assign len_too_big  = len_full > max_len_reg;

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        match_next = match_reg;
        unique case (mode_reg)
            MODE_HEADER:
            begin
                count_next = count_inc;
                if (count_inc == CNT_COMMAND)
                begin
                    xor_next = byte_in;
                end
                else if (count_inc == CNT_LEN_HIGH)
                begin
                    xor_next = xor_reg ^ byte_in;
                    len_next = {byte_in, 8'h00};
                end
                else
                begin
                    xor_next  = xor_reg ^ byte_in;
                    len_next  = len_full;
                    mode_next = len_too_big ? MODE_IDLE : MODE_BODY;
                end
            end
            MODE_BODY:
            begin
                count_next = count_inc;
                if (count_inc <= payload_end)
                begin
                    xor_next = xor_reg ^ byte_in;
                end
                else if (count_inc == checksum_pos)
                begin
                    match_next = (byte_in == xor_reg);
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (byte_in == SYNC_BYTE)
                begin
                    count_next = CNT_SYNC;
                    xor_next   = 8'h00;
                    match_next = 1'b0;
                    mode_next  = MODE_HEADER;
                end
            end
        endcase
    end

    // result for the current byte
    always_comb
    begin
        result.data_byte    = byte_in;
        result.byte_role    = ROLE_IGNORED;
        result.frame_done   = 1'b0;
        result.frame_status = STATUS_NONE;
        unique case (mode_reg)
            MODE_HEADER:
            begin
                if (count_inc == CNT_COMMAND)
                begin
                    result.byte_role = ROLE_COMMAND;
                end
                else if (count_inc == CNT_LEN_HIGH)
                begin
                    result.byte_role = ROLE_LEN_HIGH;
                end
                else
                begin
                    result.byte_role = ROLE_LEN_LOW;
                    if (len_too_big)
                    begin
                        result.frame_done   = 1'b1;
                        result.frame_status = STATUS_TOO_LONG;
                    end
                end
            end
            MODE_BODY:
            begin
                if (count_inc <= payload_end)
                begin
                    result.byte_role = ROLE_PAYLOAD;
                end
                else if (count_inc == checksum_pos)
                begin
                    result.byte_role = ROLE_CHECKSUM;
                end
                else
                begin
                    result.byte_role    = ROLE_TRAILER;
                    result.frame_done   = 1'b1;
                    result.frame_status = match_reg ? STATUS_GOOD : STATUS_BAD_CHECK;
                end
            end
            default:
            begin
                if (byte_in == SYNC_BYTE)
                begin
                    result.byte_role = ROLE_SYNC;
                end
            end
        endcase
    end

    // parse state, updated once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            xor_reg   <= '0;
            match_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
            match_reg <= match_next;
        end
    end

    // maximum payload length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            max_len_reg <= cfg_write_data;
        end
    end

endmodule

`default_nettype wire

[rtl/slxfp_out_stage.sv]
// result register stage of the frame parser
// holds one result transaction until taken; uses slxfp_pkg for the result struct
`timescale 1ns / 1ps
`default_nettype none

module slxfp_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slxfp_pkg::result_t result_d,
    input  wire logic               load,
    output logic                    free,
    output slxfp_pkg::result_t      result_q,
    output logic                    out_valid,
    input  wire logic               out_ready
);

    import slxfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // can take a new result when empty or when the held one leaves now
    assign free = !valid_reg || out_ready;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_d;
        end
    end

    assign result_q  = result_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire
